// ===== hw/rtl/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg
// Shared constants, types and a helper function for the single-halving run
// tracker: value width, end-cause codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package csh_pkg;

    // Width of the working value held by the datapath.
    localparam int VALUE_WIDTH = 64;

    // Port widths fixed by the stream interface.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    // All-ones mask and the largest value that can be tripled without overflow.
    localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = {VALUE_WIDTH{1'b1}};
    localparam logic [VALUE_WIDTH-1:0] OVF_LIMIT  = VALUE_MASK / 3;

    // Saturation point of the run-length counter.
    localparam logic [6:0] LEN_MAX = 7'd127;

    // Trailing zero count reported for a zero value.
    localparam logic [6:0] ZEROS_OF_ZERO = 7'(VALUE_WIDTH);

    // End-cause codes.
    localparam logic [1:0] CAUSE_ZEROS    = 2'd0;
    localparam logic [1:0] CAUSE_ONE      = 2'd1;
    localparam logic [1:0] CAUSE_START    = 2'd2;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd3;

    // Result word, the last field in the lowest bits.
    typedef struct packed {
        logic [63:0] record_start;
        logic [6:0]  record_length;
        logic        new_record;
        logic [1:0]  end_cause;
        logic [6:0]  final_zeros;
        logic [6:0]  run_length;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic count;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_end;
        logic need_count;
        logic count_done;
        logic out_free;
    } dp_status_t;

    // Trailing zero count of a non-zero byte.
    function automatic logic [2:0] ctz8(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/csh_ctrl.sv =====
// ----------------------------------------------------------------------------
// csh_ctrl
// Sequencing state machine: takes a word, steps the datapath until the run
// ends, runs the trailing-zero count when needed and hands off the result.
// ----------------------------------------------------------------------------
module csh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csh_pkg::dp_status_t status,
    output csh_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.run_end)
                begin
                    state_next = ST_DONE;
                end
                else if (status.need_count)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.count = 1'b1;
                if (status.count_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/csh_datapath.sv =====
// ----------------------------------------------------------------------------
// csh_datapath
// Working value, step arithmetic, trailing-zero counter, record registers
// and the output result register.
// ----------------------------------------------------------------------------
module csh_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [csh_pkg::VALUE_WIDTH-1:0]      start_in,
    input  csh_pkg::ctrl_cmd_t                   cmd,
    output csh_pkg::dp_status_t                  status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output csh_pkg::out_word_t                   out_word
);

    localparam int W = csh_pkg::VALUE_WIDTH;

    // Item registers.
    logic [W-1:0] start_reg;
    logic [W-1:0] cur_reg;
    logic [W-1:0] cnt_reg;
    logic [6:0]   steps_reg;
    logic [6:0]   zeros_reg;
    logic [1:0]   cause_reg;
    logic         first_reg;

    // Record and output registers.
    logic [6:0]          best_len_reg;
    logic [W-1:0]        best_start_reg;
    logic                out_valid_reg;
    csh_pkg::out_word_t  out_reg;

    // Step decode.
    logic         eq_one;
    logic         eq_start;
    logic         ovf;
    logic [W-1:0] nv;
    logic         new_rec;

    // One step: end checks on the current value and 3n+1 in parallel.
    assign eq_one   = !first_reg && (cur_reg == W'(1));
    assign eq_start = !first_reg && (cur_reg == start_reg);
    assign ovf      = cur_reg > csh_pkg::OVF_LIMIT;
    assign nv       = cur_reg + {cur_reg[W-2:0], 1'b0} + W'(1);

    assign status.run_end    = eq_one || eq_start || ovf;
    assign status.need_count = !(eq_one || eq_start || ovf) && (nv[1:0] == 2'b00);
    assign status.count_done = (cnt_reg == '0) || (cnt_reg[7:0] != 8'd0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign new_rec = steps_reg > best_len_reg;

    // Working value, step count and zero count.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= start_in;
            cur_reg   <= start_in;
            steps_reg <= 7'd0;
            zeros_reg <= 7'd0;
            cause_reg <= csh_pkg::CAUSE_ZEROS;
        end
        else if (cmd.step)
        begin
            if (eq_one)
            begin
                cause_reg <= csh_pkg::CAUSE_ONE;
            end
            else if (eq_start)
            begin
                cause_reg <= csh_pkg::CAUSE_START;
            end
            else if (ovf)
            begin
                cause_reg <= csh_pkg::CAUSE_OVERFLOW;
                zeros_reg <= 7'd0;
            end
            else if (nv[1:0] == 2'b00)
            begin
                cause_reg <= csh_pkg::CAUSE_ZEROS;
                zeros_reg <= 7'd0;
                cnt_reg   <= nv;
            end
            else
            begin
                // The step survives with zero or one trailing zero.
                cur_reg   <= nv >> 1;
                zeros_reg <= {6'd0, ~nv[0]};
                if (steps_reg != csh_pkg::LEN_MAX)
                begin
                    steps_reg <= steps_reg + 7'd1;
                end
            end
        end
        else if (cmd.count)
        begin
            // Eight bits a cycle; a zero value counts as the full width.
            if (cnt_reg == '0)
            begin
                zeros_reg <= csh_pkg::ZEROS_OF_ZERO;
            end
            else if (cnt_reg[7:0] == 8'd0)
            begin
                cnt_reg   <= cnt_reg >> 8;
                zeros_reg <= zeros_reg + 7'd8;
            end
            else
            begin
                zeros_reg <= zeros_reg + 7'(csh_pkg::ctz8(cnt_reg[7:0]));
            end
        end
    end

    // The first step of a run skips the checks for reaching one and for the start value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            first_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            first_reg <= 1'b0;
        end
    end

    // Record of the longest run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_len_reg   <= 7'd0;
            best_start_reg <= '0;
        end
        else if (cmd.finish && new_rec)
        begin
            best_len_reg   <= steps_reg;
            best_start_reg <= start_reg;
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.run_length  <= steps_reg;
            out_reg.final_zeros <= zeros_reg;
            out_reg.end_cause   <= cause_reg;
            out_reg.new_record  <= new_rec;
            if (new_rec)
            begin
                out_reg.record_length <= steps_reg;
                out_reg.record_start  <= 64'(start_reg);
            end
            else
            begin
                out_reg.record_length <= best_len_reg;
                out_reg.record_start  <= 64'(best_start_reg);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== hw/rtl/collatz_single_halving_run.sv =====
// ----------------------------------------------------------------------------
// collatz_single_halving_run
// Tracks the run of 3n+1 steps with at most one trailing zero for each start
// value and keeps the longest run seen so far.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents (lowest bits first)
//  s_axis    in         start_value[63:0]
//  m_axis    out        run_length[6:0], final_zeros[13:7], end_cause[15:14],
//                       new_record[16], record_length[23:17], record_start[87:24]
//
// One word is worked on at a time: the block takes it, runs the step loop
// (one 3n+1 step per cycle), counts trailing zeros at eight bits a cycle
// when the run ends on two or more zeros, and loads the result register.
// Reset clears the record, the state machine and the output valid flag.
// A stalled output holds its word; the next start value is taken meanwhile.
// ----------------------------------------------------------------------------
module collatz_single_halving_run
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [csh_pkg::IN_TDATA_W-1:0]    s_tdata,   // start_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csh_pkg::OUT_TDATA_W-1:0]   m_tdata    // run_length, final_zeros,
                                                         // end_cause, new_record,
                                                         // record_length, record_start
);

    csh_pkg::ctrl_cmd_t  cmd;
    csh_pkg::dp_status_t status;
    csh_pkg::out_word_t  out_word;

    // Sequencing.
    csh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, record and result register.
    csh_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_in  (s_tdata[csh_pkg::VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = out_word;

    // The record never falls below the run just reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_word.record_length >= out_word.run_length)
    else $error("record length below reported run length");

    // A new record reports its own run as the record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_word.new_record) |->
            (out_word.record_length == out_word.run_length))
    else $error("new record does not match run length");

    // An overflow ending makes no zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_word.end_cause == csh_pkg::CAUSE_OVERFLOW) |->
            (out_word.final_zeros == 7'd0))
    else $error("overflow ending with non-zero zero count");

    // Ends on one or start always follow a surviving step of at most one zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_word.end_cause == csh_pkg::CAUSE_ONE ||
                      out_word.end_cause == csh_pkg::CAUSE_START)) |->
            (out_word.final_zeros <= 7'd1 && out_word.run_length != 7'd0))
    else $error("value-based ending without a surviving step");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-halving run tracker. Start values go in
// over the input stream, and each result word is compared field by field
// against an in-bench prediction of the run and of the running record. A
// short table of edge cases comes first. Random phases follow, with idling
// on both sides, one long output hold-off, and pauses that let the block
// drain.
// ----------------------------------------------------------------------------
module tb;

    // Largest value that can be tripled within 64 bits.
    localparam logic [63:0] TRIPLE_LIMIT  = 64'h5555_5555_5555_5555;
    localparam logic [6:0]  LEN_SAT       = 7'd127;
    localparam logic [6:0]  ZEROS_OF_NONE = 7'd64;

    localparam int DIR_N       = 20;
    localparam int TYPED_N     = 5;
    localparam int PHASE_ITEMS = 334;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int STALL_LIMIT = 3000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    // Prediction state: the record as the block should hold it.
    logic [6:0]  rec_len   = '0;
    logic [63:0] rec_start = '0;

    csh_pkg::out_word_t run_results_q[$];
    int          err_count    = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          results_seen = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int          quiet_cycles = 0;

    logic [63:0]        dir_start [DIR_N];
    csh_pkg::out_word_t dir_want  [TYPED_N];

    collatz_single_halving_run DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the run for one start value and updates the record.
    function automatic csh_pkg::out_word_t halving_run(input logic [63:0] start);
        csh_pkg::out_word_t res;
        logic [63:0] cur;
        logic [6:0]  steps;
        logic [6:0]  zeros;
        logic [1:0]  cause;
        bit          running;
        cur     = start;
        steps   = '0;
        zeros   = '0;
        cause   = csh_pkg::CAUSE_ZEROS;
        running = 1'b1;
        while (running)
        begin
            if (cur > TRIPLE_LIMIT)
            begin
                // Overflow ends the run before any zero count is made.
                cause   = csh_pkg::CAUSE_OVERFLOW;
                zeros   = '0;
                running = 1'b0;
            end
            else
            begin
                cur   = cur * 64'd3 + 64'd1;
                zeros = ZEROS_OF_NONE;
                for (int i = 63; i >= 0; i--)
                begin
                    if (cur[i])
                    begin
                        zeros = 7'(i);
                    end
                end
                if (zeros > 7'd1)
                begin
                    cause   = csh_pkg::CAUSE_ZEROS;
                    running = 1'b0;
                end
                else
                begin
                    if (steps < LEN_SAT)
                    begin
                        steps++;
                    end
                    cur = cur >> 1;
                    // Reaching one takes precedence over returning to the start.
                    if (cur == 64'd1)
                    begin
                        cause   = csh_pkg::CAUSE_ONE;
                        running = 1'b0;
                    end
                    else if (cur == start)
                    begin
                        cause   = csh_pkg::CAUSE_START;
                        running = 1'b0;
                    end
                end
            end
        end
        res.new_record = 1'b0;
        if (steps > rec_len)
        begin
            rec_len        = steps;
            rec_start      = start;
            res.new_record = 1'b1;
        end
        res.run_length    = steps;
        res.final_zeros   = zeros;
        res.end_cause     = cause;
        res.record_length = rec_len;
        res.record_start  = rec_start;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // Offers one start value, with a random gap first, and records the
    // expected result once the word is taken.
    task automatic offer_start(input logic [63:0] v, input bit typed,
                               input csh_pkg::out_word_t want);
        csh_pkg::out_word_t pred;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pred = halving_run(v);
        run_results_q = {run_results_q, (typed ? want : pred)};
    endtask

    // Stops offering until every expected result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (run_results_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Output side: check each result word, then drive tready for the next
    // cycle, with one long hold-off part way into the first phase.
    always @(posedge clk)
    begin
        csh_pkg::out_word_t got;
        csh_pkg::out_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (run_results_q.size() == 0)
                begin
                    $error("result word 0x%0h with no expectation waiting", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = run_results_q.pop_front();
                    check_field("run_length", 64'(want.run_length),
                                64'(got.run_length));
                    check_field("final_zeros", 64'(want.final_zeros),
                                64'(got.final_zeros));
                    check_field("end_cause", 64'(want.end_cause),
                                64'(got.end_cause));
                    check_field("new_record", 64'(want.new_record),
                                64'(got.new_record));
                    check_field("record_length", 64'(want.record_length),
                                64'(got.record_length));
                    check_field("record_start", want.record_start, got.record_start);
                end
                results_seen++;
            end
            if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        logic [63:0] v;
        logic [63:0] upper;
        int          k;
        int          w;
        int          pick;

        // Edge cases; the first rows follow reset directly, so their
        // results are known without working out the run.
        dir_start = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h8000_0000_0000_0000,
                      64'h5555_5555_5555_5556, 64'h5555_5555_5555_5555, 64'd2, 64'd3,
                      64'd5, 64'd7, 64'd27, 64'hFF, 64'hFFFF, 64'hFFFF_FFFF,
                      64'h0000_00FF_FFFF_FFFF, 64'h0000_00FF_FFFF_FFFF,
                      64'h0000_3FFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0,
                      64'h3FFF_FFFF_FFFF_FFFF};
        dir_want[0] = '{record_start: 64'd0, record_length: 7'd1, new_record: 1'b1,
                        end_cause: csh_pkg::CAUSE_START, final_zeros: 7'd0,
                        run_length: 7'd1};
        dir_want[1] = '{record_start: 64'd0, record_length: 7'd1, new_record: 1'b0,
                        end_cause: csh_pkg::CAUSE_OVERFLOW, final_zeros: 7'd0,
                        run_length: 7'd0};
        dir_want[2] = '{record_start: 64'd0, record_length: 7'd1, new_record: 1'b0,
                        end_cause: csh_pkg::CAUSE_ZEROS, final_zeros: 7'd2,
                        run_length: 7'd0};
        dir_want[3] = dir_want[1];
        dir_want[4] = dir_want[1];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            offer_start(dir_start[i], i < TYPED_N, dir_want[(i < TYPED_N) ? i : 0]);
        end
        pause_until_drained();

        // Random phases: sender light and receiver heavy idling, then the
        // reverse, then none at all.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 10 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick  = $urandom_range(99);
                upper = {$urandom, $urandom};
                if (pick < 55)
                begin
                    // Low bits all ones keep the run going for many steps.
                    k = $urandom_range(62, 1);
                    w = $urandom_range(64, k);
                    v = (upper << k) | ((64'd1 << k) - 64'd1);
                    if (w < 64)
                    begin
                        v = v & ((64'd1 << w) - 64'd1);
                    end
                end
                else if (pick < 75)
                begin
                    v = upper;
                end
                else if (pick < 90)
                begin
                    v = 64'($urandom_range(1000, 0));
                end
                else
                begin
                    v = TRIPLE_LIMIT + 64'($urandom_range(8, 0)) - 64'd4;
                end
                offer_start(v, 1'b0, '0);
            end
            pause_until_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
